// ----- rtl/qic_pkg.sv -----
package qic_pkg;

   localparam int HISTORY_DEPTH_DEF = 2048;
   localparam int OFFSET_W = 11;
   localparam int COUNT_W = 5;
   localparam int FIFO_DEPTH = 4;

   typedef enum logic [1:0] {
      CMD_LIT,
      CMD_COPY,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [7:0]          data;
      logic [OFFSET_W-1:0] offset;
      logic [COUNT_W-1:0]  count;
      logic                clr;
      logic                last;
   } cmd_type;

endpackage

// ----- rtl/qic_ram.sv -----
module qic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/qic_fifo.sv -----
module qic_fifo
   import qic_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int AW = $clog2(FIFO_DEPTH);

   cmd_type          entry_ff [FIFO_DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      level_ff;

   assign full     = (level_ff == (AW+1)'(FIFO_DEPTH));
   assign empty    = (level_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push && !full, pop && !empty})
            2'b10:   level_ff <= level_ff + 1'b1;
            2'b01:   level_ff <= level_ff - 1'b1;
            default: level_ff <= level_ff;
         endcase
      end
   end

endmodule

// ----- rtl/qic_front.sv -----
module qic_front
   import qic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_start_record,
   output logic       q_push,
   output cmd_type    q_data,
   input  logic       q_full
);

   typedef enum logic [1:0] {F_IDLE, F_BITS, F_FLUSH} fstate_type;

   typedef enum logic [2:0] {
      PH_FLAG, PH_LIT, PH_OFFSEL, PH_OFF7, PH_OFF11, PH_LEN2, PH_LEN4
   } phase_type;

   fstate_type          state_ff;
   logic [7:0]          byte_ff;
   logic [2:0]          bit_idx_ff;
   phase_type           phase_ff, phase_in;
   logic [10:0]         acc_ff, acc_in;
   logic [3:0]          gat_ff, gat_in;
   logic [1:0]          short_ff, short_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic                ended_ff, ended_in;
   logic                clr_pend_ff;
   cmd_type             pend_ff;
   logic                pend_valid_ff;

   logic                gen;
   cmd_type             gen_cmd;
   logic                cur_bit;
   logic [10:0]         acc_g;
   logic [3:0]          gat_g;
   logic                stall;

   assign req_ready = (state_ff == F_IDLE);
   assign cur_bit   = byte_ff[bit_idx_ff];
   assign acc_g     = {acc_ff[9:0], cur_bit};
   assign gat_g     = gat_ff + 4'd1;

   // decode of one bit
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      gat_in   = gat_ff;
      short_in = short_ff;
      off_in   = off_ff;
      ended_in = ended_ff;
      gen      = 1'b0;
      gen_cmd  = '{kind: CMD_LIT, data: acc_g[7:0], offset: off_ff,
                   count: '0, clr: 1'b0, last: 1'b0};
      case (phase_ff)
         PH_LIT: begin
            acc_in = acc_g;
            gat_in = gat_g;
            if (gat_g >= 4'd8) begin
               gen      = 1'b1;
               phase_in = PH_FLAG;
            end
         end
         PH_OFFSEL: begin
            phase_in = cur_bit ? PH_OFF7 : PH_OFF11;
            acc_in   = '0;
            gat_in   = '0;
         end
         PH_OFF7, PH_OFF11: begin
            acc_in = acc_g;
            gat_in = gat_g;
            if (gat_g >= ((phase_ff == PH_OFF7) ? 4'd7 : 4'd11)) begin
               off_in = acc_g[OFFSET_W-1:0];
               acc_in = '0;
               gat_in = '0;
               if (acc_g[OFFSET_W-1:0] == '0) begin
                  ended_in     = 1'b1;
                  phase_in     = PH_FLAG;
                  gen          = 1'b1;
                  gen_cmd.kind = CMD_END;
               end else begin
                  phase_in = PH_LEN2;
                  short_in = '0;
               end
            end
         end
         PH_LEN2: begin
            acc_in = acc_g;
            gat_in = gat_g;
            if (gat_g >= 4'd2) begin
               acc_in       = '0;
               gat_in       = '0;
               gen          = 1'b1;
               gen_cmd.kind = CMD_COPY;
               if (acc_g[1:0] != 2'd3) begin
                  gen_cmd.count = COUNT_W'(acc_g[1:0]) + COUNT_W'(2);
                  phase_in      = PH_FLAG;
               end else begin
                  gen_cmd.count = COUNT_W'(3);
                  short_in      = short_ff + 2'd1;
                  if (short_ff + 2'd1 >= 2'd2) begin
                     phase_in = PH_LEN4;
                  end
               end
            end
         end
         PH_LEN4: begin
            acc_in = acc_g;
            gat_in = gat_g;
            if (gat_g >= 4'd4) begin
               acc_in       = '0;
               gat_in       = '0;
               gen          = 1'b1;
               gen_cmd.kind = CMD_COPY;
               if (acc_g[3:0] != 4'd15) begin
                  gen_cmd.count = COUNT_W'(acc_g[3:0]) + COUNT_W'(2);
                  phase_in      = PH_FLAG;
               end else begin
                  gen_cmd.count = COUNT_W'(15);
               end
            end
         end
         default: begin
            phase_in = cur_bit ? PH_OFFSEL : PH_LIT;
            acc_in   = '0;
            gat_in   = '0;
         end
      endcase
      gen_cmd.clr = clr_pend_ff;
   end

   assign stall = gen && pend_valid_ff && q_full;

   always_comb begin
      q_push = 1'b0;
      q_data = pend_ff;
      if (state_ff == F_BITS && !ended_ff && gen && pend_valid_ff && !q_full) begin
         q_push = 1'b1;
      end else if (state_ff == F_FLUSH && pend_valid_ff && !q_full) begin
         q_push      = 1'b1;
         q_data.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         phase_ff      <= PH_FLAG;
         acc_ff        <= '0;
         gat_ff        <= '0;
         short_ff      <= '0;
         off_ff        <= '0;
         ended_ff      <= 1'b0;
         clr_pend_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         bit_idx_ff    <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  byte_ff    <= req_data_byte;
                  bit_idx_ff <= 3'd7;
                  state_ff   <= F_BITS;
                  if (req_start_record) begin
                     phase_ff    <= PH_FLAG;
                     acc_ff      <= '0;
                     gat_ff      <= '0;
                     short_ff    <= '0;
                     off_ff      <= '0;
                     ended_ff    <= 1'b0;
                     clr_pend_ff <= 1'b1;
                  end
               end
            end
            F_BITS: begin
               if (ended_ff || !stall) begin
                  if (!ended_ff) begin
                     phase_ff <= phase_in;
                     acc_ff   <= acc_in;
                     gat_ff   <= gat_in;
                     short_ff <= short_in;
                     off_ff   <= off_in;
                     ended_ff <= ended_in;
                     if (gen) begin
                        pend_ff       <= gen_cmd;
                        pend_valid_ff <= 1'b1;
                        clr_pend_ff   <= 1'b0;
                     end
                  end
                  if (bit_idx_ff == 3'd0) begin
                     state_ff <= F_FLUSH;
                  end else begin
                     bit_idx_ff <= bit_idx_ff - 3'd1;
                  end
               end
            end
            F_FLUSH: begin
               if (!pend_valid_ff) begin
                  state_ff <= F_IDLE;
               end else if (!q_full) begin
                  pend_valid_ff <= 1'b0;
                  state_ff      <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/qic_back.sv -----
module qic_back
   import qic_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  cmd_type    q_data,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_record_done,
   output logic       rsp_last
);

   localparam int AW = $clog2(HISTORY_DEPTH);

   typedef enum logic [1:0] {B_IDLE, B_EXEC, B_DATA} bstate_type;

   bstate_type         state_ff;
   cmd_type            cmd_ff;
   logic [AW-1:0]      wpos_ff;
   logic [AW:0]        fill_ff;
   logic               hit_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_bv_ff, rsp_done_ff, rsp_last_ff;

   logic               out_free;
   logic [AW-1:0]      rd_idx;
   logic [7:0]         rd_data;
   logic               rd_en;
   logic               wr_en;
   logic [7:0]         wr_data;
   logic               copy_done;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_idx    = wpos_ff - AW'(cmd_ff.offset);
   assign rd_en     = (state_ff == B_EXEC) && (cmd_ff.kind == CMD_COPY);
   assign copy_done = (cmd_ff.count == COUNT_W'(1));
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;

   always_comb begin
      wr_en   = 1'b0;
      wr_data = cmd_ff.data;
      if (state_ff == B_EXEC && cmd_ff.kind == CMD_LIT && out_free) begin
         wr_en = 1'b1;
      end else if (state_ff == B_DATA && out_free) begin
         wr_en   = 1'b1;
         wr_data = hit_ff ? rd_data : 8'd0;
      end
   end

   qic_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wpos_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_byte_valid  = rsp_bv_ff;
   assign rsp_record_done = rsp_done_ff;
   assign rsp_last        = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            wpos_ff <= wpos_ff + 1'b1;
            if (fill_ff < (AW+1)'(HISTORY_DEPTH)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  cmd_ff   <= q_data;
                  state_ff <= B_EXEC;
                  if (q_data.clr) begin
                     wpos_ff <= '0;
                     fill_ff <= '0;
                  end
               end
            end
            B_EXEC: begin
               case (cmd_ff.kind)
                  CMD_COPY: begin
                     hit_ff   <= (fill_ff >= (AW+1)'(HISTORY_DEPTH))
                                 || ({1'b0, rd_idx} < fill_ff);
                     state_ff <= B_DATA;
                  end
                  CMD_LIT, CMD_END: begin
                     if (out_free) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_byte_ff  <= (cmd_ff.kind == CMD_LIT) ? cmd_ff.data : 8'd0;
                        rsp_bv_ff    <= (cmd_ff.kind == CMD_LIT);
                        rsp_done_ff  <= (cmd_ff.kind == CMD_END);
                        rsp_last_ff  <= cmd_ff.last;
                        state_ff     <= B_IDLE;
                     end
                  end
                  default: state_ff <= B_IDLE;
               endcase
            end
            B_DATA: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_byte_ff  <= wr_data;
                  rsp_bv_ff    <= 1'b1;
                  rsp_done_ff  <= 1'b0;
                  rsp_last_ff  <= cmd_ff.last && copy_done;
                  cmd_ff.count <= cmd_ff.count - COUNT_W'(1);
                  state_ff     <= copy_done ? B_IDLE : B_EXEC;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/qic122_decompressor_core.sv -----
// flow: a compressed word is accepted, then its bits go through the bit decoder, one bit
// per cycle unless a full token queue stalls it, then the pending token is flushed; decoded
// tokens queue up for the copy engine. throughput: the front takes a new word only once back
// in idle; the copy engine pops a token, then writes a literal, or for each copied byte reads
// history, then writes and emits it; a stalled output holds the engine
// reset: synchronous, clears decoder, queue and output; history contents are not
// cleared, unwritten positions read zero through the fill count
module qic122_decompressor_core
   import qic_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_start_record,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_record_done,
   output logic       rsp_last
);

   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_in, q_out;

   qic_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_start_record (req_start_record),
      .q_push           (q_push),
      .q_data           (q_in),
      .q_full           (q_full)
   );

   qic_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   qic_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_out),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_record_done (rsp_record_done),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- tb/tb_qic122_decompressor_core.sv -----
module tb_qic122_decompressor_core;
   import qic_pkg::*;

   typedef enum logic [2:0] {
      PH_FLAG, PH_LIT, PH_OFFSEL, PH_OFF7, PH_OFF11, PH_LEN2, PH_LEN4
   } phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       record_done;
      logic       last;
   } result_type;

   localparam int DEPTH = HISTORY_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 1500000;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [7:0] req_data_byte = 0;
   logic       req_start_record = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_record_done;
   logic       rsp_last;

   qic122_decompressor_core dut (.*);

   always #4 clock = ~clock;

   // decoder shadow
   logic [7:0]  hist [DEPTH];
   logic [10:0] wpos;
   logic [11:0] fill;
   phase_type   phase;
   logic [10:0] acc;
   logic [3:0]  nbits;
   logic [10:0] moff;
   logic [1:0]  short_cnt;
   logic        ended;

   word_type   pending_words[$];
   result_type expected_bytes[$];
   result_type step_out[$];

   int errors = 0, cycles = 0, words_sent = 0, bytes_seen = 0, records = 0;
   bit quiet = 0;
   bit hold_off = 0;
   bit in_taken = 0;

   function automatic void clear_decoder();
      wpos = '0; fill = '0; phase = PH_FLAG; acc = '0; nbits = '0;
      moff = '0; short_cnt = '0; ended = 1'b0;
   endfunction

   function automatic void put_byte(logic [7:0] v);
      result_type r;
      hist[wpos] = v;
      wpos = wpos + 11'd1;
      if (fill < 12'(DEPTH)) fill = fill + 12'd1;
      r = '{v, 1'b1, 1'b0, 1'b0};
      step_out = {step_out, r};
   endfunction

   function automatic void copy_run(int n);
      logic [10:0] idx;
      logic [7:0]  v;
      for (int i = 0; i < n; i++) begin
         idx = wpos - moff;
         v = (fill >= 12'(DEPTH) || {1'b0, idx} < fill) ? hist[idx] : 8'h00;
         put_byte(v);
      end
   endfunction

   function automatic void shift_in(logic b);
      acc = {acc[9:0], b};
      nbits = nbits + 4'd1;
   endfunction

   function automatic void decode_bit(logic b);
      int n;
      result_type r;
      case (phase)
         PH_LIT: begin
            shift_in(b);
            if (nbits >= 4'd8) begin
               put_byte(acc[7:0]);
               phase = PH_FLAG;
            end
         end
         PH_OFFSEL: begin
            phase = b ? PH_OFF7 : PH_OFF11;
            acc = '0; nbits = '0;
         end
         PH_OFF7, PH_OFF11: begin
            shift_in(b);
            if (nbits >= ((phase == PH_OFF7) ? 4'd7 : 4'd11)) begin
               moff = acc; acc = '0; nbits = '0;
               if (moff == '0) begin
                  ended = 1'b1;
                  phase = PH_FLAG;
                  r = '{8'h00, 1'b0, 1'b1, 1'b0};
                  step_out = {step_out, r};
               end else begin
                  phase = PH_LEN2;
                  short_cnt = '0;
               end
            end
         end
         PH_LEN2: begin
            shift_in(b);
            if (nbits >= 4'd2) begin
               n = int'(acc[1:0]); acc = '0; nbits = '0;
               if (n < 3) begin
                  copy_run(n + 2);
                  phase = PH_FLAG;
               end else begin
                  copy_run(3);
                  short_cnt = short_cnt + 2'd1;
                  if (short_cnt >= 2'd2) phase = PH_LEN4;
               end
            end
         end
         PH_LEN4: begin
            shift_in(b);
            if (nbits >= 4'd4) begin
               n = int'(acc[3:0]); acc = '0; nbits = '0;
               if (n < 15) begin
                  copy_run(n + 2);
                  phase = PH_FLAG;
               end else begin
                  copy_run(15);
               end
            end
         end
         default: begin
            phase = b ? PH_OFFSEL : PH_LIT;
            acc = '0; nbits = '0;
         end
      endcase
   endfunction

   function automatic void predict_word(word_type w);
      result_type r;
      if (w.start) clear_decoder();
      step_out.delete();
      for (int b = 7; b >= 0; b--) begin
         if (ended) break;
         decode_bit(w.data[b]);
      end
      if (step_out.size() > 0) begin
         r = step_out[$];
         r.last = 1'b1;
         step_out[$] = r;
      end
      expected_bytes = {expected_bytes, step_out};
   endfunction

   // bit packer used to build well-formed streams
   logic [7:0] pack_cur;
   int         pack_n;
   bit         pack_start;

   function automatic void flush_byte();
      word_type w;
      w.data = pack_cur;
      w.start = pack_start;
      pending_words = {pending_words, w};
      pack_start = 0; pack_cur = 0; pack_n = 0;
   endfunction

   function automatic void put_bits(int v, int width);
      for (int i = width - 1; i >= 0; i--) begin
         pack_cur[7 - pack_n] = 1'((v >> i) & 1);
         pack_n++;
         if (pack_n == 8) flush_byte();
      end
   endfunction

   function automatic void put_copy(int off, int len_extra);
      // len_extra selects how many chunks: exercises 2-bit and 4-bit forms
      put_bits(1, 1);
      if (off < 128 && $urandom_range(0, 1)) begin
         put_bits(1, 1); put_bits(off, 7);
      end else begin
         put_bits(0, 1); put_bits(off, 11);
      end
      if (len_extra < 3) begin
         put_bits(len_extra, 2);
      end else begin
         put_bits(3, 2);
         if (len_extra == 3) put_bits($urandom_range(0, 2), 2);
         else begin
            put_bits(3, 2);
            for (int k = 0; k < len_extra - 4; k++) put_bits(15, 4);
            put_bits($urandom_range(0, 14), 4);
         end
      end
   endfunction

   function automatic void make_record(int tokens, bit with_end);
      pack_start = 1; pack_cur = 0; pack_n = 0;
      for (int t = 0; t < tokens; t++) begin
         if ($urandom_range(0, 2) == 0) begin
            put_bits(0, 1);
            put_bits($urandom_range(0, 255), 8);
         end else begin
            put_copy($urandom_range(0, 9) < 7 ? $urandom_range(1, 20)
                                              : $urandom_range(1, 2047),
                     $urandom_range(0, 5));
         end
      end
      if (with_end) begin
         put_bits(1, 1); put_bits(1, 1); put_bits(0, 7);
      end
      if (pack_n > 0) begin
         pack_cur = pack_cur | ((8'hff >> pack_n) & 8'($urandom_range(0, 255)));
         flush_byte();
      end
      // trailing bytes after the end marker are ignored
      if (with_end && $urandom_range(0, 1)) begin
         word_type w;
         w.data = 8'($urandom_range(0, 255));
         w.start = 0;
         pending_words = {pending_words, w};
      end
   endfunction

   // driver
   always @(negedge clock) begin
      word_type w;
      if (!reset) begin
         if (!req_valid || in_taken) begin
            if (!hold_off && pending_words.size() > 0 &&
                (quiet || $urandom_range(0, 99) >= 25)) begin
               w = pending_words.pop_front();
               req_valid <= 1;
               req_data_byte <= w.data;
               req_start_record <= w.start;
            end else begin
               req_valid <= 0;
            end
         end
         in_taken = 0;
         rsp_ready <= quiet || $urandom_range(0, 99) >= 25;
      end
   end

   // monitor
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset) begin
         cycles++;
         if (req_valid && req_ready) begin
            predict_word('{req_data_byte, req_start_record});
            words_sent++;
            in_taken = 1;
         end
         if (rsp_valid && rsp_ready) begin
            bytes_seen++;
            if (rsp_record_done) records++;
            if (expected_bytes.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected word: byte %02h bv %0b done %0b last %0b",
                           rsp_out_byte, rsp_byte_valid, rsp_record_done, rsp_last);
            end else begin
               exp_r = expected_bytes.pop_front();
               if (exp_r != {rsp_out_byte, rsp_byte_valid, rsp_record_done, rsp_last}) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp byte %02h bv %0b done %0b last %0b, got %02h %0b %0b %0b",
                              exp_r.out_byte, exp_r.byte_valid, exp_r.record_done,
                              exp_r.last, rsp_out_byte, rsp_byte_valid,
                              rsp_record_done, rsp_last);
               end
            end
         end
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_qic122_decompressor_core: FAIL");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_bytes.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      word_type w;
      for (int i = 0; i < DEPTH; i++) hist[i] = '0;
      clear_decoder();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: literals at extremes, short and long copies, end markers
      pack_start = 1; pack_cur = 0; pack_n = 0;
      put_bits(0, 1); put_bits(8'h00, 8);
      put_bits(0, 1); put_bits(8'hff, 8);
      put_copy(1, 0);
      put_copy(2047, 2);          // reads unwritten history
      put_copy(3, 3);
      put_copy(5, 4);
      put_copy(127, 6);           // long 4-bit run
      put_bits(1, 1); put_bits(0, 1); put_bits(0, 11);  // long-form end marker
      if (pack_n > 0) flush_byte();
      pending_words = {pending_words, word_type'{8'hff, 1'b0}};
      pending_words = {pending_words, word_type'{8'hc0, 1'b1}};  // short end marker
      pending_words = {pending_words, word_type'{8'h5a, 1'b0}};
      pending_words = {pending_words, word_type'{8'h00, 1'b1}};  // partial token only
      pending_words = {pending_words, word_type'{8'h7f, 1'b0}};
      wait_drained();

      // sender holds off before the record goes out, and again once all bytes have drained
      make_record(6, 1);
      hold_off = 1;
      repeat (20) @(posedge clock);
      hold_off = 0;
      wait_drained();
      hold_off = 1;
      repeat (40) @(posedge clock);
      hold_off = 0;

      // random: mostly records, some noise
      while (words_sent < 420) begin
         if ($urandom_range(0, 9) < 8) make_record($urandom_range(1, 12), $urandom_range(0, 3) != 0);
         else begin
            repeat ($urandom_range(1, 6)) begin
               w.data = 8'($urandom_range(0, 255));
               w.start = $urandom_range(0, 3) == 0;
               pending_words = {pending_words, w};
            end
         end
         quiet = (words_sent > 150 && words_sent < 230);
         wait_drained();
      end
      quiet = 0;

      wait_drained();
      repeat (100) @(posedge clock);
      $display("sent %0d compressed words, checked %0d output words, %0d record ends",
               words_sent, bytes_seen, records);
      if (errors == 0 && expected_bytes.size() == 0) begin
         $display("tb_qic122_decompressor_core: PASS");
      end else begin
         $display("%0d errors, %0d outputs still expected", errors, expected_bytes.size());
         $display("tb_qic122_decompressor_core: FAIL");
      end
      $finish;
   end

endmodule
